// ----- hdl/lmfa_pkg.sv -----
`timescale 1ns / 1ps

package lmfa_pkg;

  localparam int unsigned FrameColsDefault   = 30;
  localparam int unsigned FrameRowsDefault   = 30;
  localparam int unsigned ChunkPixelsDefault = 240;
  localparam int unsigned LastChunkDefault   = 3;

  localparam int unsigned FieldW = 8;
  localparam int unsigned ColorW = 3 * FieldW;
  localparam int unsigned InDataW = 7 * FieldW;

  localparam logic [FieldW-1:0] LitValue = 8'd1;

  localparam logic [ColorW-1:0] ColorReset = {8'd255, 8'd0, 8'd255};

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_TICK  = 1'b1
  } req_e;

endpackage

// ----- hdl/led_matrix_frame_assembler.sv -----
`timescale 1ns / 1ps

// Frame assembler for a FRAME_COLS x FRAME_ROWS monochrome LED matrix with serpentine
// scan-out. The block sustains one input item (pixel write or scan tick) per clock while
// the output is not stalled; the single-port frame memory is read by a tick and written
// by a pixel write in the cycle the item is accepted, and the LED color appears on the
// output the cycle after its tick. While an LED item waits on the output, no input item
// is accepted. After reset the frame memory is cleared by a pass over all
// FRAME_COLS * FRAME_ROWS locations (900 by default), during which no item is accepted.
module led_matrix_frame_assembler #(
  parameter int unsigned FRAME_COLS   = lmfa_pkg::FrameColsDefault,
  parameter int unsigned FRAME_ROWS   = lmfa_pkg::FrameRowsDefault,
  parameter int unsigned CHUNK_PIXELS = lmfa_pkg::ChunkPixelsDefault,
  parameter int unsigned LAST_CHUNK   = lmfa_pkg::LastChunkDefault,
  localparam int unsigned TotalPix    = FRAME_COLS * FRAME_ROWS,
  localparam int unsigned PosW        = $clog2(TotalPix),
  localparam int unsigned OutDataW    = ((PosW + lmfa_pkg::ColorW + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // chunk_index, row_count, pixel_pos, pixel_value, red_in, green_in, blue_in
  input  logic [lmfa_pkg::InDataW-1:0] s_axis_tdata_i,
  // req_type
  input  logic                         s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // led_position, red_out, green_out, blue_out, zero padding
  output logic [OutDataW-1:0]          m_axis_tdata_o,
  // last_led
  output logic                         m_axis_tlast_o
);

  localparam int unsigned CalcW = 8 + $clog2(CHUNK_PIXELS + FRAME_COLS + 1);
  localparam int unsigned ColW  = $clog2(FRAME_COLS);

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

  state_e                        state_q;
  logic [PosW-1:0]               clr_addr_q;
  logic                          frame_ready_q;
  logic                          scan_active_q;
  logic [PosW-1:0]               scan_pos_q;
  logic [ColW-1:0]               scan_col_q;
  logic                          scan_odd_q;
  logic [lmfa_pkg::ColorW-1:0]   cur_color_q;
  logic [lmfa_pkg::ColorW-1:0]   scan_color_q;
  logic                          out_valid_q;
  logic [PosW-1:0]               out_pos_q;
  logic [lmfa_pkg::ColorW-1:0]   out_color_q;
  logic                          out_last_q;
  logic                          lit_q;
  logic                          mem_q [TotalPix];

  logic [lmfa_pkg::FieldW-1:0]   chunk;
  logic [lmfa_pkg::FieldW-1:0]   rows;
  logic [lmfa_pkg::FieldW-1:0]   pos;
  logic [lmfa_pkg::FieldW-1:0]   value;
  logic [lmfa_pkg::ColorW-1:0]   in_color;
  logic [CalcW-1:0]              offset;
  logic [CalcW-1:0]              len;
  logic [CalcW-1:0]              wr_addr;
  logic                          overflow;
  logic                          accept;
  logic                          do_write;
  logic                          do_emit;
  logic                          scan_last;
  logic [PosW:0]                 src_wide;
  logic [PosW-1:0]               src_addr;
  logic [lmfa_pkg::ColorW-1:0]   shown;

  assign chunk    = s_axis_tdata_i[7:0];
  assign rows     = s_axis_tdata_i[15:8];
  assign pos      = s_axis_tdata_i[23:16];
  assign value    = s_axis_tdata_i[31:24];
  assign in_color = {s_axis_tdata_i[39:32], s_axis_tdata_i[47:40], s_axis_tdata_i[55:48]};

  assign offset   = CalcW'(chunk) * CalcW'(CHUNK_PIXELS);
  assign len      = CalcW'(rows) * CalcW'(FRAME_COLS);
  assign wr_addr  = offset + CalcW'(pos);
  assign overflow = (offset + len) > CalcW'(TotalPix);

  assign s_axis_tready_o = (state_q == ST_RUN) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign do_write        = accept && (s_axis_tuser_i == lmfa_pkg::REQ_WRITE) && !overflow
                           && (CalcW'(pos) < len) && (wr_addr < CalcW'(TotalPix));
  assign do_emit         = accept && (s_axis_tuser_i == lmfa_pkg::REQ_TICK) && scan_active_q;

  assign scan_last = scan_pos_q == PosW'(TotalPix - 1);
  assign src_wide  = scan_odd_q ? {1'b0, scan_pos_q}
                   : (PosW + 1)'(scan_pos_q) + (PosW + 1)'(FRAME_COLS - 1)
                     - ((PosW + 1)'(scan_col_q) << 1);
  assign src_addr  = src_wide[PosW-1:0];

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      mem_q[clr_addr_q] <= 1'b0;
    end else if (do_write) begin
      mem_q[wr_addr[PosW-1:0]] <= (value == lmfa_pkg::LitValue);
    end
    if (do_emit) begin
      lit_q <= mem_q[src_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_addr_q    <= '0;
      frame_ready_q <= 1'b0;
      scan_active_q <= 1'b0;
      scan_pos_q    <= '0;
      scan_col_q    <= '0;
      scan_odd_q    <= 1'b0;
      cur_color_q   <= lmfa_pkg::ColorReset;
      scan_color_q  <= '0;
      out_valid_q   <= 1'b0;
      out_pos_q     <= '0;
      out_color_q   <= '0;
      out_last_q    <= 1'b0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (clr_addr_q == PosW'(TotalPix - 1)) begin
            state_q <= ST_RUN;
          end else begin
            clr_addr_q <= clr_addr_q + 1'b1;
          end
        end
        ST_RUN: begin
          if (m_axis_tready_i) begin
            out_valid_q <= 1'b0;
          end
          if (accept) begin
            if (s_axis_tuser_i == lmfa_pkg::REQ_WRITE) begin
              cur_color_q <= in_color;
              if (!overflow && (chunk == lmfa_pkg::FieldW'(LAST_CHUNK))) begin
                frame_ready_q <= 1'b1;
              end
            end else if (!scan_active_q) begin
              if (frame_ready_q) begin
                frame_ready_q <= 1'b0;
                scan_active_q <= 1'b1;
                scan_pos_q    <= '0;
                scan_col_q    <= '0;
                scan_odd_q    <= 1'b0;
                scan_color_q  <= cur_color_q;
              end
            end else begin
              out_valid_q <= 1'b1;
              out_pos_q   <= scan_pos_q;
              out_color_q <= scan_color_q;
              out_last_q  <= scan_last;
              if (scan_last) begin
                scan_active_q <= 1'b0;
                scan_pos_q    <= '0;
              end else begin
                scan_pos_q <= scan_pos_q + 1'b1;
                if (scan_col_q == ColW'(FRAME_COLS - 1)) begin
                  scan_col_q <= '0;
                  scan_odd_q <= !scan_odd_q;
                end else begin
                  scan_col_q <= scan_col_q + 1'b1;
                end
              end
            end
          end
        end
        default: begin
          state_q <= ST_CLEAR;
        end
      endcase
    end
  end

  assign shown           = lit_q ? out_color_q : '0;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = OutDataW'({shown[7:0], shown[15:8], shown[23:16], out_pos_q});

endmodule
